### design/u8sd_pkg.sv
// ---------------------------------------------------------------------------
// u8sd_pkg
// Types and constants shared by the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
package u8sd_pkg;

    localparam int CODE_W = 21;
    localparam int LEN_W  = 3;
    localparam int STAT_W = 2;
    localparam int PEND_W = 2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STAT_W-1:0] ST_TRUNCATED = 2'd2;

    localparam logic [CODE_W-1:0] MAX_ASCII  = 21'h00007f;
    localparam logic [CODE_W-1:0] MIN_TWO    = 21'h000080;
    localparam logic [CODE_W-1:0] MAX_TWO    = 21'h0007ff;
    localparam logic [CODE_W-1:0] MIN_THREE  = 21'h000800;
    localparam logic [CODE_W-1:0] MAX_THREE  = 21'h00ffff;
    localparam logic [CODE_W-1:0] MIN_FOUR   = 21'h010000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_byte;

    typedef struct packed {
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  seq_length;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

### design/u8sd_if.sv
// ---------------------------------------------------------------------------
// u8sd_if
// Valid/ready channels for input bytes and decoded code points.
// ---------------------------------------------------------------------------
interface u8sd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u8sd_code_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_value;
    logic [2:0]  seq_length;
    logic [1:0]  status;

    modport source (output valid, output code_value, output seq_length, output status,
                    input ready);
    modport sink (input valid, input code_value, input seq_length, input status,
                  output ready);
endinterface

### design/u8sd_in_reg.sv
// ---------------------------------------------------------------------------
// u8sd_in_reg
// Input register that holds one byte until the decode stage takes it.
// ---------------------------------------------------------------------------
module u8sd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    u8sd_byte_if.sink       i_in,
    input  logic            i_take,
    output logic            o_valid,
    output u8sd_pkg::t_byte o_word
);
    import u8sd_pkg::*;

    logic  r_valid;
    t_byte r_word;
    logic  w_open;

    assign w_open     = !r_valid || i_take;
    assign i_in.ready = w_open;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_open) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_open && i_in.valid) begin
            r_word <= '{data_byte: i_in.data_byte, final_byte: i_in.final_byte};
        end
    end
endmodule

### design/u8sd_core.sv
// ---------------------------------------------------------------------------
// u8sd_core
// Sequence state and decode of one registered byte per cycle, unless stalled.
// ---------------------------------------------------------------------------
module u8sd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  u8sd_pkg::t_byte   i_word,
    input  logic              i_out_busy,
    output logic              o_take,
    output logic              o_load,
    output u8sd_pkg::t_result o_result
);
    import u8sd_pkg::*;

    logic [PEND_W-1:0] r_pending, n_pending;
    logic [CODE_W-1:0] r_partial, n_partial;
    logic [LEN_W-1:0]  r_size, n_size;

    logic              w_emit;
    t_result           w_res;
    logic [CODE_W-1:0] w_shift;
    logic [PEND_W-1:0] w_left;
    logic              w_in_range;
    logic [7:0]        w_b;
    logic              w_last;

    assign w_b     = i_word.data_byte;
    assign w_last  = i_word.final_byte;
    assign w_shift = {r_partial[CODE_W-7:0], w_b[5:0]};
    assign w_left  = r_pending - 2'd1;

    always_comb begin
        unique case (r_size)
            3'd2:    w_in_range = (w_shift >= MIN_TWO) && (w_shift <= MAX_TWO);
            3'd3:    w_in_range = (w_shift >= MIN_THREE) && (w_shift <= MAX_THREE);
            default: w_in_range = (w_shift >= MIN_FOUR);
        endcase
    end

    always_comb begin
        w_emit    = 1'b0;
        w_res     = '{code_value: '0, seq_length: 3'd1, status: ST_OK};
        n_pending = r_pending;
        n_partial = r_partial;
        n_size    = r_size;
        if (r_pending == 2'd0) begin
            priority if (w_b[7] == 1'b0) begin
                w_emit           = 1'b1;
                w_res.code_value = {13'd0, w_b};
            end else if (w_b[7:5] == 3'b110) begin
                n_partial = {16'd0, w_b[4:0]};
                n_pending = 2'd1;
                n_size    = 3'd2;
            end else if (w_b[7:4] == 4'b1110) begin
                n_partial = {17'd0, w_b[3:0]};
                n_pending = 2'd2;
                n_size    = 3'd3;
            end else if (w_b[7:3] == 5'b11110) begin
                n_partial = {18'd0, w_b[2:0]};
                n_pending = 2'd3;
                n_size    = 3'd4;
            end else begin
                w_emit       = 1'b1;
                w_res.status = ST_MALFORMED;
            end
            if (!w_emit && w_last) begin
                w_emit       = 1'b1;
                w_res.status = ST_TRUNCATED;
            end
        end else begin
            n_partial = w_shift;
            n_pending = w_left;
            if (w_left == 2'd0) begin
                w_emit           = 1'b1;
                w_res.seq_length = r_size;
                w_res.status     = w_in_range ? ST_OK : ST_MALFORMED;
                w_res.code_value = w_in_range ? w_shift : '0;
            end else if (w_last) begin
                w_emit           = 1'b1;
                w_res.seq_length = r_size - {1'b0, w_left};
                w_res.status     = ST_TRUNCATED;
            end
        end
        if (w_emit) begin
            n_pending = '0;
            n_partial = '0;
            n_size    = '0;
        end
    end

    assign o_take   = i_valid && (!w_emit || !i_out_busy);
    assign o_load   = o_take && w_emit;
    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_partial <= '0;
            r_size    <= '0;
        end else if (o_take) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_size    <= n_size;
        end
    end
endmodule

### design/u8sd_out_reg.sv
// ---------------------------------------------------------------------------
// u8sd_out_reg
// Result register that drives the code point channel.
// ---------------------------------------------------------------------------
module u8sd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  u8sd_pkg::t_result i_result,
    output logic              o_busy,
    u8sd_code_if.source       o_out
);
    import u8sd_pkg::*;

    logic    r_valid;
    t_result r_word;

    assign o_busy           = r_valid && !o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.code_value = r_word.code_value;
    assign o_out.seq_length = r_word.seq_length;
    assign o_out.status     = r_word.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_result;
        end
    end
endmodule

### design/utf8_stream_decoder_top.sv
// ---------------------------------------------------------------------------
// utf8_stream_decoder_top
// Decodes a UTF-8 byte stream into code points with length and status.
//
//   Channel   Direction  Carries
//   i_in      input      data_byte, final_byte
//   o_out     output     code_value, seq_length, status
//
// A byte is held in the input register and decoded there, and its result is
// then loaded into the output register, which drives o_out.
// One byte is accepted per cycle unless the input stalls; bytes that
// complete nothing still advance.
// Reset is synchronous and returns the decoder to idle with no result held.
// A stalled output holds its result; the input stalls only when a byte that
// produces a result finds the output register occupied and not being drained.
// ---------------------------------------------------------------------------
module utf8_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8sd_byte_if.sink   i_in,
    u8sd_code_if.source o_out
);
    import u8sd_pkg::*;

    logic    w_in_valid;
    t_byte   w_in_word;
    logic    w_take;
    logic    w_load;
    logic    w_busy;
    t_result w_result;

    u8sd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_word  (w_in_word)
    );

    u8sd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_in_valid),
        .i_word     (w_in_word),
        .i_out_busy (w_busy),
        .o_take     (w_take),
        .o_load     (w_load),
        .o_result   (w_result)
    );

    u8sd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .o_busy   (w_busy),
        .o_out    (o_out)
    );
endmodule

### design/u8sd_checker.sv
// ---------------------------------------------------------------------------
// u8sd_checker
// Port-level checks on the decoded code point channel.
// ---------------------------------------------------------------------------
module u8sd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [20:0] i_code_value,
    input logic [2:0]  i_seq_length,
    input logic [1:0]  i_status
);
    import u8sd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_code_value)
            && $stable(i_seq_length) && $stable(i_status))
        else $error("Stalled result changed.");

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ST_OK |-> i_code_value == '0)
        else $error("Error result carries a code point.");

    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_seq_length != 3'd0 && i_seq_length <= 3'd4 && i_status != 2'd3)
        else $error("Result length or status out of range.");

    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_OK && i_seq_length == 3'd1 |-> i_code_value <= MAX_ASCII)
        else $error("Single byte result above the ASCII range.");

    a_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_OK && i_seq_length == 3'd2
            |-> i_code_value >= MIN_TWO && i_code_value <= MAX_TWO)
        else $error("Two byte result outside its range.");
endmodule

bind utf8_stream_decoder_top u8sd_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_code_value (o_out.code_value),
    .i_seq_length (o_out.seq_length),
    .i_status     (o_out.status)
);
